/* sv/prsc_pkg.sv */
// shared types, constants and codes of the palm region sum classifier
package prsc_pkg;

	localparam int FRONT_ROWS_DEF = 32;
	localparam int FRONT_COLS_DEF = 18;
	localparam int BACK_ROWS_DEF  = 24;
	localparam int BACK_COLS_DEF  = 14;
	localparam int CMD_DEPTH_DEF  = 4;

	localparam int FE_ROW_LO     = 14;
	localparam int BE_TOP_COL_LO = 9;
	localparam int BE_BOT_COL_LO = 7;

	localparam logic [1:0] CFG_FRONT_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_BACK_THRESHOLD  = 2'd1;
	localparam logic [1:0] CFG_TIE_MARGIN      = 2'd2;
	localparam logic [1:0] CFG_FRONT_GAIN      = 2'd3;

	localparam logic [14:0] FRONT_THRESHOLD_RST = 15'd50;
	localparam logic [14:0] BACK_THRESHOLD_RST  = 15'd150;
	localparam logic [15:0] TIE_MARGIN_RST      = 16'd500;
	localparam logic [3:0]  FRONT_GAIN_RST      = 4'd3;

	localparam logic [1:0] SCR_FRONT     = 2'd0;
	localparam logic [1:0] SCR_BACK      = 2'd1;
	localparam logic [1:0] SCR_UNDECIDED = 2'd2;

	typedef struct packed {
		logic        front_edge;
		logic        front_middle;
		logic        back_edge;
		logic        back_middle;
		logic [14:0] value;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [31:0] front_edge;
		logic [31:0] back_edge;
		logic [31:0] front_middle;
		logic [31:0] back_middle;
	} sums_t;

	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_MUL,
		DEC_SCALE,
		DEC_CMP,
		DEC_OUT
	} dec_state_t;

endpackage

/* sv/prsc_front.sv */
// front part: region decode and threshold check of one sample into a command
module prsc_front import prsc_pkg::*; #(
	parameter int FRONT_ROWS = FRONT_ROWS_DEF,
	parameter int FRONT_COLS = FRONT_COLS_DEF,
	parameter int BACK_ROWS  = BACK_ROWS_DEF,
	parameter int BACK_COLS  = BACK_COLS_DEF
) (
	input  logic               from_back,
	input  logic [4:0]         row_index,
	input  logic [4:0]         column_index,
	input  logic signed [15:0] sample_value,
	input  logic               frame_end,
	input  logic [14:0]        front_threshold,
	input  logic [14:0]        back_threshold,
	output cmd_t               cmd
);

	logic [5:0] row_x;
	logic [5:0] col_x;
	logic       front_hit;
	logic       back_hit;
	logic       edge_col;

	assign row_x = {1'b0, row_index};
	assign col_x = {1'b0, column_index};

	always_comb begin
		front_hit = !from_back && row_x < 6'(FRONT_ROWS) && col_x < 6'(FRONT_COLS)
			&& sample_value > $signed({1'b0, front_threshold});
		back_hit = from_back && row_x < 6'(BACK_ROWS) && col_x < 6'(BACK_COLS)
			&& sample_value > $signed({1'b0, back_threshold});
		edge_col = col_x <= 6'd1 || col_x >= 6'(FRONT_COLS - 2);

		cmd.front_edge = front_hit && edge_col && row_x >= 6'(FE_ROW_LO)
			&& row_x <= 6'(FRONT_ROWS - 6);
		cmd.front_middle = front_hit && row_x >= 6'd2 && row_x < 6'(FRONT_ROWS / 2)
			&& col_x >= 6'd2 && col_x <= 6'(FRONT_COLS - 3);
		cmd.back_edge = back_hit
			&& ((row_x == 6'd1 && col_x >= 6'(BE_TOP_COL_LO))
			|| (row_x >= 6'(BACK_ROWS - 2) && col_x >= 6'(BE_BOT_COL_LO)));
		cmd.back_middle = back_hit && row_x >= 6'd2 && row_x <= 6'(BACK_ROWS - 3)
			&& col_x >= 6'd2 && col_x < 6'(BACK_COLS / 2);
		cmd.value = sample_value[14:0];
		cmd.last  = frame_end;
	end

endmodule

/* sv/prsc_cmd_fifo.sv */
// short command queue between the front and the accumulators
module prsc_cmd_fifo import prsc_pkg::*; #(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign valid   = count_q != '0;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/prsc_accum.sv */
// back part: saturating region accumulators, handing frame sums to the decision unit
module prsc_accum import prsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  logic  cmd_valid,
	output logic  cmd_pop,
	input  logic  dec_ready,
	output logic  dec_start,
	output sums_t dec_sums
);

	sums_t sums_q;
	sums_t sums_d;

	function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [14:0] v);
		logic [32:0] s;
		s = {1'b0, acc} + {18'b0, v};
		return s[32] ? '1 : s[31:0];
	endfunction

	always_comb begin
		sums_d.front_edge   = cmd.front_edge ? sat_add(sums_q.front_edge, cmd.value)
			: sums_q.front_edge;
		sums_d.back_edge    = cmd.back_edge ? sat_add(sums_q.back_edge, cmd.value)
			: sums_q.back_edge;
		sums_d.front_middle = cmd.front_middle ? sat_add(sums_q.front_middle, cmd.value)
			: sums_q.front_middle;
		sums_d.back_middle  = cmd.back_middle ? sat_add(sums_q.back_middle, cmd.value)
			: sums_q.back_middle;
		cmd_pop   = cmd_valid && (!cmd.last || dec_ready);
		dec_start = cmd_pop && cmd.last;
		dec_sums  = sums_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (cmd_pop) begin
			sums_q <= cmd.last ? '0 : sums_d;
		end
	end

endmodule

/* sv/prsc_decide.sv */
// decision unit: gain and grid ratio scaling by cross multiplication, tie check, result register
module prsc_decide import prsc_pkg::*; #(
	parameter int FRONT_ROWS = FRONT_ROWS_DEF,
	parameter int FRONT_COLS = FRONT_COLS_DEF,
	parameter int BACK_ROWS  = BACK_ROWS_DEF,
	parameter int BACK_COLS  = BACK_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  sums_t       sums,
	output logic        ready,
	input  logic [3:0]  front_gain,
	input  logic [15:0] tie_margin,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  screen,
	output logic        used_middle
);

	localparam int NUM = FRONT_ROWS * FRONT_COLS;
	localparam int DEN = BACK_ROWS * BACK_COLS;
	localparam int FW  = 36;
	localparam int XW  = 32 + $clog2(NUM);
	localparam int DB  = $clog2(DEN + 1);
	localparam int CW  = ((FW + 1 + DB) > (XW + 1)) ? (FW + 1 + DB) : (XW + 1);
	localparam logic [XW-1:0] NUM_X = XW'(NUM);
	localparam logic [CW-1:0] DEN_C = CW'(DEN);

	dec_state_t    state_q;
	dec_state_t    state_d;
	sums_t         sums_q;
	logic [FW-1:0] fe_prod_q;
	logic [FW-1:0] fm_prod_q;
	logic [XW-1:0] xe_q;
	logic [XW-1:0] xm_q;
	logic [CW-1:0] ae_q;
	logic [CW-1:0] am_q;
	logic [CW-1:0] he_q;
	logic [CW-1:0] hm_q;
	logic [CW-1:0] xte_q;
	logic [CW-1:0] xtm_q;
	logic          ge_e_q;
	logic          ge_m_q;
	logic          und_e_q;
	logic          und_m_q;
	logic          out_valid_q;
	logic [1:0]    screen_q;
	logic          used_q;

	logic [FW-1:0] fe_prod;
	logic [FW-1:0] fm_prod;
	logic [XW-1:0] be_prod;
	logic [XW-1:0] bm_prod;
	logic [CW-1:0] margin_x;
	logic [CW-1:0] ae;
	logic [CW-1:0] am;
	logic [CW-1:0] he;
	logic [CW-1:0] hm;
	logic [CW-1:0] xte;
	logic [CW-1:0] xtm;
	logic          ge_e;
	logic          ge_m;
	logic          und_e;
	logic          und_m;
	logic [1:0]    scr_e;
	logic [1:0]    scr_m;
	logic          load_out;

	assign fe_prod = FW'(sums_q.front_edge) * FW'(front_gain);
	assign fm_prod = FW'(sums_q.front_middle) * FW'(front_gain);
	assign be_prod = XW'(sums_q.back_edge) * NUM_X;
	assign bm_prod = XW'(sums_q.back_middle) * NUM_X;

	// the scaled back sum is compared against front bounds times the grid divisor
	assign margin_x = CW'(tie_margin);
	assign ae       = (CW'(fe_prod_q) + CW'(1)) * DEN_C;
	assign am       = (CW'(fm_prod_q) + CW'(1)) * DEN_C;
	assign he       = (CW'(fe_prod_q) + margin_x) * DEN_C;
	assign hm       = (CW'(fm_prod_q) + margin_x) * DEN_C;
	assign xte      = CW'(xe_q) + margin_x * DEN_C;
	assign xtm      = CW'(xm_q) + margin_x * DEN_C;

	assign ge_e  = ae_q > CW'(xe_q);
	assign ge_m  = am_q > CW'(xm_q);
	assign und_e = ge_e ? (xte_q >= ae_q) : (CW'(xe_q) < he_q);
	assign und_m = ge_m ? (xtm_q >= am_q) : (CW'(xm_q) < hm_q);

	assign ready       = state_q == DEC_IDLE;
	assign empty       = !out_valid_q;
	assign screen      = screen_q;
	assign used_middle = used_q;

	always_comb begin
		scr_e    = und_e_q ? SCR_UNDECIDED : (ge_e_q ? SCR_FRONT : SCR_BACK);
		scr_m    = und_m_q ? SCR_UNDECIDED : (ge_m_q ? SCR_FRONT : SCR_BACK);
		load_out = 1'b0;
		state_d  = state_q;
		case (state_q)
			DEC_IDLE: begin
				if (start) begin
					state_d = DEC_MUL;
				end
			end
			DEC_MUL: begin
				state_d = DEC_SCALE;
			end
			DEC_SCALE: begin
				state_d = DEC_CMP;
			end
			DEC_CMP: begin
				state_d = DEC_OUT;
			end
			DEC_OUT: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = DEC_IDLE;
				end
			end
			default: begin
				state_d = DEC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DEC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DEC_IDLE: begin
				if (start) begin
					sums_q <= sums;
				end
			end
			DEC_MUL: begin
				fe_prod_q <= fe_prod;
				fm_prod_q <= fm_prod;
				xe_q      <= be_prod;
				xm_q      <= bm_prod;
			end
			DEC_SCALE: begin
				ae_q  <= ae;
				am_q  <= am;
				he_q  <= he;
				hm_q  <= hm;
				xte_q <= xte;
				xtm_q <= xtm;
			end
			DEC_CMP: begin
				ge_e_q  <= ge_e;
				ge_m_q  <= ge_m;
				und_e_q <= und_e;
				und_m_q <= und_m;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			screen_q <= (scr_e == SCR_UNDECIDED) ? scr_m : scr_e;
			used_q   <= scr_e == SCR_UNDECIDED;
		end
	end

endmodule

/* sv/palm_region_sum_classifier_unit.sv */
// top level of the palm region sum classifier
// Samples are taken one per cycle whenever full is low; the front decodes each
// sample and queues a command, and the accumulators retire one command per
// cycle unless a frame_end command waits for the decision unit. On the frame_end
// sample the four sums go to the decision unit and the accumulators clear, so
// the next frame streams on without a gap. The result passes in turn through
// the command queue, the capture of the sums, gain and grid scaling, bound
// scaling, comparison and the result register load, which waits while an
// earlier result is unread. The decision unit takes no new frame until its
// result is loaded, so a frame_end that arrives while the previous frame is
// still being decided, or while its result is still unread, waits in the
// command queue, and full rises once that queue fills.
module palm_region_sum_classifier_unit import prsc_pkg::*; #(
	parameter int FRONT_ROWS = FRONT_ROWS_DEF,
	parameter int FRONT_COLS = FRONT_COLS_DEF,
	parameter int BACK_ROWS  = BACK_ROWS_DEF,
	parameter int BACK_COLS  = BACK_COLS_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic               from_back,
	input  logic [4:0]         row_index,
	input  logic [4:0]         column_index,
	input  logic signed [15:0] sample_value,
	input  logic               frame_end,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         screen,
	output logic               used_middle
);

	logic [14:0] front_threshold_q;
	logic [14:0] back_threshold_q;
	logic [15:0] tie_margin_q;
	logic [3:0]  front_gain_q;

	cmd_t  front_cmd;
	cmd_t  head_cmd;
	logic  head_valid;
	logic  head_pop;
	logic  dec_ready;
	logic  dec_start;
	sums_t dec_sums;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_threshold_q <= FRONT_THRESHOLD_RST;
			back_threshold_q  <= BACK_THRESHOLD_RST;
			tie_margin_q      <= TIE_MARGIN_RST;
			front_gain_q      <= FRONT_GAIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FRONT_THRESHOLD: front_threshold_q <= cfg_data[14:0];
				CFG_BACK_THRESHOLD:  back_threshold_q  <= cfg_data[14:0];
				CFG_TIE_MARGIN:      tie_margin_q      <= cfg_data;
				CFG_FRONT_GAIN:      front_gain_q      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	prsc_front #(
		.FRONT_ROWS(FRONT_ROWS),
		.FRONT_COLS(FRONT_COLS),
		.BACK_ROWS (BACK_ROWS),
		.BACK_COLS (BACK_COLS)
	) u_front (
		.from_back      (from_back),
		.row_index      (row_index),
		.column_index   (column_index),
		.sample_value   (sample_value),
		.frame_end      (frame_end),
		.front_threshold(front_threshold_q),
		.back_threshold (back_threshold_q),
		.cmd            (front_cmd)
	);

	prsc_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_cmd),
		.full  (full),
		.pop   (head_pop),
		.rdata (head_cmd),
		.valid (head_valid)
	);

	prsc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (head_cmd),
		.cmd_valid(head_valid),
		.cmd_pop  (head_pop),
		.dec_ready(dec_ready),
		.dec_start(dec_start),
		.dec_sums (dec_sums)
	);

	prsc_decide #(
		.FRONT_ROWS(FRONT_ROWS),
		.FRONT_COLS(FRONT_COLS),
		.BACK_ROWS (BACK_ROWS),
		.BACK_COLS (BACK_COLS)
	) u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (dec_start),
		.sums       (dec_sums),
		.ready      (dec_ready),
		.front_gain (front_gain_q),
		.tie_margin (tie_margin_q),
		.empty      (empty),
		.pop        (pop),
		.screen     (screen),
		.used_middle(used_middle)
	);

endmodule

/* sv/prsc_checker.sv */
// port-level checks of the palm region sum classifier and their bind
module prsc_checker import prsc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [1:0] screen,
	input logic       used_middle
);

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(screen) && $stable(used_middle))
		else $error("result changed before its transfer");

	// a result from the edge pass is always decided
	a_edge_decided: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !used_middle |-> screen != SCR_UNDECIDED)
		else $error("undecided result without middle pass");

	// the result register empties only by a transfer
	a_empty_by_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result vanished without transfer");

	// the input side fills only by a push
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind palm_region_sum_classifier_unit prsc_checker u_prsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.screen     (screen),
	.used_middle(used_middle)
);
